### rtl/bounded_ordered_char_list_assert.svh
// Assertion macros for the bounded ordered byte list.
// Included by the port checker; depends on nothing else.
`ifndef BOUNDED_ORDERED_CHAR_LIST_ASSERT_SVH
`define BOUNDED_ORDERED_CHAR_LIST_ASSERT_SVH

// Same-cycle implication, switched off while reset is held.
`define BOCL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bocl: same-cycle check failed");

// Next-cycle implication, switched off while reset is held.
`define BOCL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bocl: next-cycle check failed");

`endif

### rtl/bocl_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the bounded ordered byte list.
// Used by the controller, the datapath, the top level and the checker.
package bocl_pkg;

    localparam logic [1:0] MODE_INS_FRONT = 2'd0;
    localparam logic [1:0] MODE_INS_AFTER = 2'd1;
    localparam logic [1:0] MODE_DEL_FRONT = 2'd2;
    localparam logic [1:0] MODE_DEL_AFTER = 2'd3;

    localparam logic [2:0] ST_DONE   = 3'd0;
    localparam logic [2:0] ST_FULL   = 3'd1;
    localparam logic [2:0] ST_NOKEY  = 3'd2;
    localparam logic [2:0] ST_EMPTY  = 3'd3;
    localparam logic [2:0] ST_NOSUCC = 3'd4;

    typedef struct packed {
        logic load;
        logic search;
        logic update;
    } t_cmd;

endpackage

### rtl/bocl_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the bounded ordered byte list: accept, search, update.
// Depends on bocl_pkg for the command struct.
module bocl_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output bocl_pkg::t_cmd o_cmd
);
    import bocl_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SRCH = 3'b010,
        S_UPD  = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   out_free;
    logic   load;
    logic   update;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) || ((r_state == S_UPD) && out_free);
    assign load       = i_in_valid && o_in_ready;
    assign update     = (r_state == S_UPD) && out_free;

    assign o_cmd.load   = load;
    assign o_cmd.search = (r_state == S_SRCH);
    assign o_cmd.update = update;
    assign o_out_valid  = r_out_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (load) begin
                    n_state = S_SRCH;
                end
            end
            S_SRCH: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                if (out_free) begin
                    n_state = load ? S_SRCH : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (update) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

### rtl/bocl_datapath.sv
`timescale 1ns / 1ps
// Entry cells, key compare, status decision and result register of the list.
// Depends on bocl_pkg; driven by bocl_ctrl through the command struct.
module bocl_datapath #(
    parameter int CAPACITY = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bocl_pkg::t_cmd i_cmd,
    input  logic [1:0]     i_mode,
    input  logic [7:0]     i_search_key,
    input  logic [7:0]     i_new_entry,
    output logic [2:0]     o_status,
    output logic [2:0]     o_entry_count
);
    import bocl_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int XW = (CW > 3) ? CW : 3;

    logic [1:0]    r_mode;
    logic [7:0]    r_key;
    logic [7:0]    r_val;
    logic [7:0]    r_entries [CAPACITY];
    logic [CW-1:0] r_fill;
    logic [CW-1:0] r_p;
    logic [2:0]    r_status;
    logic [2:0]    r_out_status;
    logic [2:0]    r_out_count;

    logic [CAPACITY-1:0] match;
    logic [CAPACITY-1:0] first;
    logic [IW-1:0]       pos;
    logic                found;
    logic [CW-1:0]       pos1;
    logic                full;
    logic                empty;
    logic [2:0]          n_status;
    logic [CW-1:0]       n_p;
    logic                is_ins;
    logic                apply;
    logic [CW-1:0]       n_fill;
    logic [XW-1:0]       n_fill_x;

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            match[i] = (CW'(i) < r_fill) && (r_entries[i] == r_key);
        end
    end

    assign first = match & (~match + {{(CAPACITY-1){1'b0}}, 1'b1});
    assign found = |match;

    always_comb begin
        pos = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            pos = pos | (first[i] ? IW'(i) : IW'(0));
        end
    end

    assign pos1  = CW'(pos) + CW'(1);
    assign full  = r_fill >= CW'(CAPACITY);
    assign empty = r_fill == '0;

    always_comb begin
        n_status = ST_DONE;
        n_p      = pos1;
        unique case (r_mode)
            MODE_INS_FRONT: begin
                n_p = '0;
                if (full) begin
                    n_status = ST_FULL;
                end
            end
            MODE_INS_AFTER: begin
                if (full) begin
                    n_status = ST_FULL;
                end else if (!found) begin
                    n_status = ST_NOKEY;
                end
            end
            MODE_DEL_FRONT: begin
                n_p = '0;
                if (empty) begin
                    n_status = ST_EMPTY;
                end
            end
            MODE_DEL_AFTER: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else if (!found || (pos1 >= r_fill)) begin
                    n_status = ST_NOSUCC;
                end
            end
            default: begin
                n_status = ST_DONE;
            end
        endcase
    end

    assign is_ins   = (r_mode == MODE_INS_FRONT) || (r_mode == MODE_INS_AFTER);
    assign apply    = i_cmd.update && (r_status == ST_DONE);
    assign n_fill   = (r_status != ST_DONE) ? r_fill :
                      (is_ins ? r_fill + CW'(1) : r_fill - CW'(1));
    assign n_fill_x = XW'(n_fill);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_mode;
            r_key  <= i_search_key;
            r_val  <= i_new_entry;
        end
        if (i_cmd.search) begin
            r_status <= n_status;
            r_p      <= n_p;
        end
        if (i_cmd.update) begin
            r_out_status <= r_status;
            r_out_count  <= n_fill_x[2:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_cmd.update) begin
            r_fill <= n_fill;
        end
    end

    // Each cell takes its own new byte, its front neighbour on insert
    // or its back neighbour on delete.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        localparam int PREV = (g == 0) ? 0 : g - 1;
        localparam int NEXT = (g == CAPACITY - 1) ? g : g + 1;
        always_ff @(posedge i_clk) begin
            if (apply) begin
                if (is_ins) begin
                    if (CW'(g) == r_p) begin
                        r_entries[g] <= r_val;
                    end else if (CW'(g) > r_p) begin
                        r_entries[g] <= r_entries[PREV];
                    end
                end else if (CW'(g) >= r_p) begin
                    r_entries[g] <= r_entries[NEXT];
                end
            end
        end
    end

    assign o_status      = r_out_status;
    assign o_entry_count = r_out_count;

endmodule

### rtl/bounded_ordered_char_list.sv
`timescale 1ns / 1ps
// Top level of the bounded ordered byte list.
// Depends on bocl_pkg, bocl_ctrl and bocl_datapath.
//
//  channel  | direction | tuser      | tdata (lowest bit first)
//  s_axis   | request   | mode [1:0] | search_key [7:0], new_entry [15:8]
//  m_axis   | result    | -          | status [2:0], entry_count [5:3], zeros [7:6]
//
// Each request has its key compared with every cell in the search state,
// then the update state shifts the cells and loads the result register.
// A new request is taken in the update cycle when the result register is free.
// Reset clears the entry count; the cells need no clearing.
// A stalled result holds the block in its update cycle.
module bounded_ordered_char_list #(
    parameter int CAPACITY = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // search_key, new_entry
    input  logic [1:0]  s_axis_tuser,  // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata   // status, entry_count, zero padding
);
    import bocl_pkg::*;

    t_cmd       cmd;
    logic [2:0] status;
    logic [2:0] entry_count;

    bocl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd)
    );

    bocl_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_mode        (s_axis_tuser),
        .i_search_key  (s_axis_tdata[7:0]),
        .i_new_entry   (s_axis_tdata[15:8]),
        .o_status      (status),
        .o_entry_count (entry_count)
    );

    assign m_axis_tdata = {2'b00, entry_count, status};

endmodule

### rtl/bocl_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the bounded ordered byte list, bound to the top level.
// Depends on bocl_pkg and bounded_ordered_char_list_assert.svh.
`include "bounded_ordered_char_list_assert.svh"

module bocl_checker #(
    parameter int CAPACITY = 4
) (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);
    import bocl_pkg::*;

    `BOCL_ASSERT_IMP(a_status_range, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[2:0] <= ST_NOSUCC)
    `BOCL_ASSERT_IMP(a_full_count, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tdata[2:0] == ST_FULL), m_axis_tdata[5:3] == 3'(CAPACITY))
    `BOCL_ASSERT_IMP(a_empty_count, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tdata[2:0] == ST_EMPTY), m_axis_tdata[5:3] == 3'd0)
    `BOCL_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind bounded_ordered_char_list bocl_checker #(
    .CAPACITY (CAPACITY)
) u_bocl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

### tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the bounded ordered byte list (bounded_ordered_char_list).
// It depends on bocl_pkg and the top level. It drives requests, predicts each status
// and count, and compares every result item against that prediction.
module testbench;
    import bocl_pkg::*;

    localparam int CAPACITY    = 4;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 60;

    typedef struct {
        logic [1:0] mode;
        logic [7:0] key;
        logic [7:0] entry;
        bit         drain;
    } t_request;

    typedef struct {
        logic [2:0] status;
        logic [2:0] count;
    } t_outcome;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;   // search_key, new_entry
    logic [1:0]  s_axis_tuser = '0;   // mode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;        // status, entry_count, zero padding

    bounded_ordered_char_list #(.CAPACITY(CAPACITY)) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_request    requests_pending[$];
    t_outcome    outcomes_due[$];
    t_request    req_on_bus;
    logic [7:0]  list_cells[CAPACITY];
    int unsigned list_len = 0;
    int unsigned cyc = 0;
    int unsigned hold_left = 0;
    int unsigned stall_cycles = 0;
    int unsigned mismatches = 0;
    int unsigned requests_done = 0;
    int unsigned status_seen[5] = '{default: 0};
    logic [7:0]  alphabet[6];

    function automatic bit idle_now();
        if (cyc >= 3000 && cyc < 3800)
            return 1'b0;
        return $urandom_range(99) < 38;
    endfunction

    function automatic t_outcome apply_request(t_request req);
        t_outcome res;
        int pos;
        int i;
        res.status = ST_DONE;
        pos = int'(list_len);
        for (i = int'(list_len) - 1; i >= 0; i--)
            if (list_cells[i] == req.key)
                pos = i;
        case (req.mode) inside
            MODE_INS_FRONT, MODE_INS_AFTER: begin
                if (list_len >= CAPACITY) begin
                    res.status = ST_FULL;
                end else if (req.mode == MODE_INS_AFTER && pos >= int'(list_len)) begin
                    res.status = ST_NOKEY;
                end else begin
                    if (req.mode == MODE_INS_FRONT)
                        pos = -1;
                    for (i = int'(list_len); i > pos + 1; i--)
                        list_cells[i] = list_cells[i - 1];
                    list_cells[pos + 1] = req.entry;
                    list_len++;
                end
            end
            default: begin
                if (list_len == 0) begin
                    res.status = ST_EMPTY;
                end else if (req.mode == MODE_DEL_AFTER && pos + 1 >= int'(list_len)) begin
                    res.status = ST_NOSUCC;
                end else begin
                    if (req.mode == MODE_DEL_FRONT)
                        pos = -1;
                    for (i = pos + 1; i + 1 < int'(list_len); i++)
                        list_cells[i] = list_cells[i + 1];
                    list_len--;
                end
            end
        endcase
        res.count = list_len[2:0];
        return res;
    endfunction

    task automatic queue_request(logic [1:0] mode, logic [7:0] key, logic [7:0] entry,
                                 bit drain = 1'b0);
        t_request req;
        req.mode  = mode;
        req.key   = key;
        req.entry = entry;
        req.drain = drain;
        requests_pending.push_back(req);
    endtask

    function automatic logic [7:0] pick_byte();
        if ($urandom_range(99) < 70)
            return alphabet[$urandom_range(5)];
        return 8'($urandom_range(255));
    endfunction

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
    end

    // Request driver: a pending item is held on the bus until it is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                outcomes_due.push_back(apply_request(req_on_bus));
                requests_done++;
            end
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                if (requests_pending.size() != 0 && !idle_now() &&
                    !(requests_pending[0].drain && outcomes_due.size() != 0)) begin
                    req_on_bus = requests_pending.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {req_on_bus.entry, req_on_bus.key};
                    s_axis_tuser  <= req_on_bus.mode;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-offs, so that the block fills up and refuses new requests.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (cyc == 1500 || cyc == 5000) begin
            hold_left <= HOLD_CYCLES;
        end
    end

    // Result monitor and checker.
    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (outcomes_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result item: status %0d count %0d",
                                 m_axis_tdata[2:0], m_axis_tdata[5:3]);
                end else begin
                    want = outcomes_due.pop_front();
                    if (want.status < 5)
                        status_seen[want.status]++;
                    if (m_axis_tdata[2:0] !== want.status ||
                        m_axis_tdata[5:3] !== want.count ||
                        m_axis_tdata[7:6] !== 2'b00) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: got status %0d count %0d pad %b, ",
                                      "expected status %0d count %0d"},
                                     m_axis_tdata[2:0], m_axis_tdata[5:3], m_axis_tdata[7:6],
                                     want.status, want.count);
                    end
                end
            end
            m_axis_tready <= (hold_left == 0) && !idle_now();
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("testbench NOT OK");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int n;
        for (n = 0; n < CAPACITY; n++)
            list_cells[n] = '0;
        for (n = 0; n < 6; n++)
            alphabet[n] = 8'($urandom_range(255));

        // Directed part: empty and full lists, absent keys, key on the last entry,
        // duplicate keys and the byte extremes.
        queue_request(MODE_DEL_FRONT, 8'hFF, 8'hFF);
        queue_request(MODE_DEL_AFTER, 8'h00, 8'hFF);
        queue_request(MODE_INS_AFTER, 8'h00, 8'h12);
        queue_request(MODE_INS_FRONT, 8'hFF, 8'h00);
        queue_request(MODE_INS_FRONT, 8'h00, 8'hFF);
        queue_request(MODE_INS_AFTER, 8'hFF, 8'h5A);
        queue_request(MODE_INS_AFTER, 8'h00, 8'hA5);
        queue_request(MODE_INS_FRONT, 8'h00, 8'h11);
        queue_request(MODE_INS_AFTER, 8'h77, 8'h22);
        queue_request(MODE_DEL_AFTER, 8'hA5, 8'h00);
        queue_request(MODE_DEL_AFTER, 8'h33, 8'hFF);
        queue_request(MODE_DEL_AFTER, 8'hFF, 8'h00);
        queue_request(MODE_INS_AFTER, 8'h42, 8'h24);
        queue_request(MODE_INS_AFTER, 8'h00, 8'h00);
        queue_request(MODE_DEL_AFTER, 8'h00, 8'h55);
        queue_request(MODE_INS_FRONT, 8'hAA, 8'h00);
        queue_request(MODE_DEL_FRONT, 8'h00, 8'h00);
        queue_request(MODE_INS_AFTER, 8'h00, 8'h7F);
        for (n = 0; n < 5; n++)
            queue_request(MODE_DEL_FRONT, 8'h00, 8'h00);

        for (n = 0; n < 1800; n++)
            queue_request(2'($urandom_range(3)), pick_byte(), pick_byte(), (n % 450) == 0);

        do @(posedge i_clk);
        while (requests_pending.size() != 0 || s_axis_tvalid || outcomes_due.size() != 0);
        repeat (10) @(posedge i_clk);

        $display("%0d requests: %0d done, %0d full, %0d key not found,",
                 requests_done, status_seen[ST_DONE], status_seen[ST_FULL],
                 status_seen[ST_NOKEY]);
        $display("%0d empty, %0d no successor", status_seen[ST_EMPTY], status_seen[ST_NOSUCC]);
        if (mismatches == 0 && outcomes_due.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, outcomes_due.size());
            $display("testbench NOT OK");
        end
        $finish;
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

endmodule

### files.f
+incdir+rtl
rtl/bocl_pkg.sv
rtl/bocl_ctrl.sv
rtl/bocl_datapath.sv
rtl/bounded_ordered_char_list.sv
rtl/bocl_checker.sv
tb/testbench.sv
